@@ hdl/rsm_pkg.sv @@
// shared constants, types and the fractional power-of-two table for the row softmax
package rsm_pkg;

  localparam int MAX_COLS    = 64;
  localparam int SCORE_WIDTH = 16;

  localparam int IDX_W   = $clog2(MAX_COLS);
  localparam int CNT_W   = $clog2(MAX_COLS + 1);
  localparam int PROB_W  = 16;
  localparam int EXP_W   = 17;
  localparam int SUM_W   = 23;
  localparam int NUM_W   = EXP_W + PROB_W + 1;
  localparam int DIV_STEPS = EXP_W;
  localparam int STEP_W  = $clog2(DIV_STEPS);
  localparam int DIFF_W  = SCORE_WIDTH + 1;
  localparam int MQ_W    = 13;
  localparam int PROD_W  = MQ_W + EXP_W;

  localparam logic [EXP_W-1:0]  LOG2E_Q16   = 17'd94548;
  localparam logic [MQ_W-1:0]   FLUSH_LIMIT = 13'd4096;
  localparam logic [PROD_W-1:0] ROUND_HALF  = 30'd32768;

  typedef struct packed {
    logic load;
    logic idx_clr;
    logic idx_inc;
    logic exp_mul;
    logic exp_acc;
    logic div_init;
    logic div_step;
    logic out_load;
    logic row_clr;
  } rsm_cmd_t;

  typedef struct packed {
    logic last_idx;
    logic div_last;
    logic out_free;
  } rsm_status_t;

  function automatic logic [EXP_W-1:0] pow2_frac(input logic [4:0] k);
    logic [EXP_W-1:0] v;
    case (k)
      5'd0:    v = 17'd65536;
      5'd1:    v = 17'd62757;
      5'd2:    v = 17'd60097;
      5'd3:    v = 17'd57549;
      5'd4:    v = 17'd55109;
      5'd5:    v = 17'd52773;
      5'd6:    v = 17'd50535;
      5'd7:    v = 17'd48393;
      5'd8:    v = 17'd46341;
      5'd9:    v = 17'd44376;
      5'd10:   v = 17'd42495;
      5'd11:   v = 17'd40693;
      5'd12:   v = 17'd38968;
      5'd13:   v = 17'd37316;
      5'd14:   v = 17'd35734;
      5'd15:   v = 17'd34219;
      5'd16:   v = 17'd32768;
      default: v = 17'd32768;
    endcase
    return v;
  endfunction

endpackage

@@ hdl/rsm_if.sv @@
// valid/ready channel interfaces for scores in and probabilities out
interface rsm_score_if;
  import rsm_pkg::*;
  logic                          valid;
  logic                          ready;
  logic signed [SCORE_WIDTH-1:0] score;
  logic                          row_end;
  modport source (output valid, score, row_end, input ready);
  modport sink   (input valid, score, row_end, output ready);
endinterface

interface rsm_prob_if;
  import rsm_pkg::*;
  logic              valid;
  logic              ready;
  logic [PROB_W-1:0] probability;
  logic              last_of_row;
  logic              row_overflow;
  modport source (output valid, probability, last_of_row, row_overflow, input ready);
  modport sink   (input valid, probability, last_of_row, row_overflow, output ready);
endinterface

@@ hdl/row_softmax_unit.sv @@
// top level of the row softmax: controller plus datapath
// scores stream in at one transfer per cycle until the row end transfer
// after row end: an exponent and sum pass reads, multiplies and accumulates each
// element, then each element is read, run through the 17-step serial divider and
// loaded to the output register, which waits while out stalls
// reset is asynchronous active low; clears control, maximum, sum, count, overflow, index and output valid
module row_softmax_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  rsm_score_if.sink   in_i,
  rsm_prob_if.source  out_o
);
  import rsm_pkg::*;

  rsm_cmd_t    cmd;
  rsm_status_t status;

  rsm_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_i.valid),
    .in_row_end_i (in_i.row_end),
    .in_ready_o   (in_i.ready),
    .status_i     (status),
    .cmd_o        (cmd)
  );

  rsm_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .score_i        (in_i.score),
    .out_ready_i    (out_o.ready),
    .out_valid_o    (out_o.valid),
    .probability_o  (out_o.probability),
    .last_of_row_o  (out_o.last_of_row),
    .row_overflow_o (out_o.row_overflow)
  );

endmodule

@@ hdl/rsm_ctrl.sv @@
// sequencing state machine for the load, exponent and division passes
module rsm_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_row_end_i,
  output logic                 in_ready_o,
  input  rsm_pkg::rsm_status_t status_i,
  output rsm_pkg::rsm_cmd_t    cmd_o
);
  import rsm_pkg::*;

  typedef enum logic [7:0] {
    S_LOAD  = 8'b0000_0001,
    S_ERD   = 8'b0000_0010,
    S_EMUL  = 8'b0000_0100,
    S_EINT  = 8'b0000_1000,
    S_DRD   = 8'b0001_0000,
    S_DINIT = 8'b0010_0000,
    S_DSTEP = 8'b0100_0000,
    S_DOUT  = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;
  logic   xfer;

  assign in_ready_o = (state_q == S_LOAD);
  assign xfer       = in_valid_i & in_ready_o;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_LOAD: begin
        cmd_o.load = xfer;
        if (xfer && in_row_end_i) begin
          cmd_o.idx_clr = 1'b1;
          state_d = S_ERD;
        end
      end
      S_ERD: state_d = S_EMUL;
      S_EMUL: begin
        cmd_o.exp_mul = 1'b1;
        state_d = S_EINT;
      end
      S_EINT: begin
        cmd_o.exp_acc = 1'b1;
        if (status_i.last_idx) begin
          cmd_o.idx_clr = 1'b1;
          state_d = S_DRD;
        end else begin
          cmd_o.idx_inc = 1'b1;
          state_d = S_ERD;
        end
      end
      S_DRD: state_d = S_DINIT;
      S_DINIT: begin
        cmd_o.div_init = 1'b1;
        state_d = S_DSTEP;
      end
      S_DSTEP: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_last) state_d = S_DOUT;
      end
      S_DOUT: begin
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          if (status_i.last_idx) begin
            cmd_o.row_clr = 1'b1;
            cmd_o.idx_clr = 1'b1;
            state_d = S_LOAD;
          end else begin
            cmd_o.idx_inc = 1'b1;
            state_d = S_DRD;
          end
        end
      end
      default: state_d = S_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ hdl/rsm_datapath.sv @@
// row store, maximum, exponential, running sum, serial divider and output register
module rsm_datapath (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  rsm_pkg::rsm_cmd_t                     cmd_i,
  output rsm_pkg::rsm_status_t                  status_o,
  input  logic signed [rsm_pkg::SCORE_WIDTH-1:0] score_i,
  input  logic                                  out_ready_i,
  output logic                                  out_valid_o,
  output logic [rsm_pkg::PROB_W-1:0]            probability_o,
  output logic                                  last_of_row_o,
  output logic                                  row_overflow_o
);
  import rsm_pkg::*;

  logic signed [SCORE_WIDTH-1:0] store_mem [MAX_COLS];
  logic [EXP_W-1:0]              exp_mem   [MAX_COLS];
  logic signed [SCORE_WIDTH-1:0] store_rd_q;
  logic [EXP_W-1:0]              exp_rd_q;

  logic signed [SCORE_WIDTH-1:0] max_q;
  logic [CNT_W-1:0]              count_q;
  logic                          ovf_q;
  logic [SUM_W-1:0]              total_q;
  logic [IDX_W-1:0]              idx_q;

  logic [PROD_W-1:0] prod_q;
  logic              flush_q;

  logic [SUM_W-1:0]  rem_q;
  logic [EXP_W-1:0]  nbits_q;
  logic [EXP_W-1:0]  quo_q;
  logic [STEP_W-1:0] step_q;

  logic                  out_valid_q;
  logic [PROB_W-1:0]     prob_q;
  logic                  last_q;
  logic                  ovf_out_q;

  // exponent stage signals
  logic [DIFF_W-1:0]      diff;
  logic [DIFF_W+MQ_W-1:0] diff_ext;
  logic                   flush_d;
  logic [PROD_W-1:0]      u_full;
  logic [MQ_W-1:0]        u;
  logic [4:0]             k;
  logic [3:0]             r;
  logic [EXP_W-1:0]       t0, t1, tdiff, v;
  logic [EXP_W+3:0]       interp;
  logic [EXP_W-1:0]       e_val;

  // divider signals
  logic [NUM_W-1:0] num;
  logic [SUM_W:0]   trial;
  logic             ge;

  logic store_full;
  logic last_idx;

  assign store_full = (count_q == CNT_W'(MAX_COLS));
  assign last_idx   = ({1'b0, idx_q} == (count_q - CNT_W'(1)));

  assign diff     = DIFF_W'($signed({max_q[SCORE_WIDTH-1], max_q})
                            - $signed({store_rd_q[SCORE_WIDTH-1], store_rd_q}));
  assign diff_ext = {{MQ_W{1'b0}}, diff};
  assign flush_d  = (diff_ext > {{DIFF_W{1'b0}}, FLUSH_LIMIT});

  assign u_full = (prod_q + ROUND_HALF) >> 16;
  assign u      = u_full[MQ_W-1:0];
  assign k      = {1'b0, u[7:4]};
  assign r      = u[3:0];
  assign t0     = pow2_frac(k);
  assign t1     = pow2_frac(k + 5'd1);
  assign tdiff  = t0 - t1;
  assign interp = ({4'b0, tdiff} * {{EXP_W{1'b0}}, r} + (EXP_W+4)'(8)) >> 4;
  assign v      = t0 - interp[EXP_W-1:0];
  assign e_val  = flush_q ? '0 : (v >> u[MQ_W-1:8]);

  assign num   = {1'b0, exp_rd_q, {PROB_W{1'b0}}} + NUM_W'(total_q >> 1);
  assign trial = {rem_q, nbits_q[EXP_W-1]};
  assign ge    = (trial >= {1'b0, total_q});

  always_ff @(posedge clk_i) begin
    if (cmd_i.load && !store_full) store_mem[count_q[IDX_W-1:0]] <= score_i;
    if (cmd_i.exp_acc) exp_mem[idx_q] <= e_val;
    store_rd_q <= store_mem[idx_q];
    exp_rd_q   <= exp_mem[idx_q];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exp_mul) begin
      prod_q  <= diff_ext[MQ_W-1:0] * LOG2E_Q16;
      flush_q <= flush_d;
    end
    if (cmd_i.div_init) begin
      rem_q   <= SUM_W'(num[NUM_W-1:EXP_W]);
      nbits_q <= num[EXP_W-1:0];
      step_q  <= '0;
    end else if (cmd_i.div_step) begin
      rem_q   <= ge ? SUM_W'(trial - {1'b0, total_q}) : trial[SUM_W-1:0];
      nbits_q <= nbits_q << 1;
      quo_q   <= {quo_q[EXP_W-2:0], ge};
      step_q  <= step_q + STEP_W'(1);
    end
    if (cmd_i.out_load) begin
      prob_q    <= quo_q[EXP_W-1] ? {PROB_W{1'b1}} : quo_q[PROB_W-1:0];
      last_q    <= last_idx;
      ovf_out_q <= ovf_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q       <= {1'b1, {(SCORE_WIDTH-1){1'b0}}};
      count_q     <= '0;
      ovf_q       <= 1'b0;
      total_q     <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.row_clr) begin
        max_q   <= {1'b1, {(SCORE_WIDTH-1){1'b0}}};
        count_q <= '0;
        ovf_q   <= 1'b0;
        total_q <= '0;
      end else begin
        if (cmd_i.load) begin
          if (store_full) begin
            ovf_q <= 1'b1;
          end else begin
            count_q <= count_q + CNT_W'(1);
            if (score_i > max_q) max_q <= score_i;
          end
        end
        if (cmd_i.exp_acc) total_q <= total_q + SUM_W'(e_val);
      end
      if (cmd_i.idx_clr) idx_q <= '0;
      else if (cmd_i.idx_inc) idx_q <= idx_q + IDX_W'(1);
      if (cmd_i.out_load) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  assign status_o.last_idx = last_idx;
  assign status_o.div_last = (step_q == STEP_W'(DIV_STEPS - 1));
  assign status_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o    = out_valid_q;
  assign probability_o  = prob_q;
  assign last_of_row_o  = last_q;
  assign row_overflow_o = ovf_out_q;

endmodule
